// ===== rtl/core/group_reorder_buffer_assert.svh =====
// Assertion macros shared by the reorder buffer RTL
`ifndef GROUP_REORDER_BUFFER_ASSERT_SVH
`define GROUP_REORDER_BUFFER_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define GRB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("reorder buffer check failed");

// next-cycle implication
`define GRB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("reorder buffer check failed");

`endif

// ===== rtl/core/grb_pkg.sv =====
// Types, constants and status codes of the group reorder buffer
package grb_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int RESULT_CAP    = 16;
   localparam int RUN_W         = $clog2(RESULT_CAP + 1);

   localparam logic [31:0] NEXT_RESET = 32'd1;
   localparam logic [31:0] MIN_RESET  = 32'hFFFF_FFFF;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   localparam logic [1:0] ST_RELEASED = 2'd0;
   localparam logic [1:0] ST_DUP_KEY  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic [31:0] member_id;
      logic [15:0] group_tag;
      logic        last_member;
   } req_word_type;

   typedef struct packed {
      logic [15:0] out_tag;
      logic [31:0] out_first_id;
      logic [15:0] out_size;
      logic [1:0]  status;
      logic        last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] size;
      logic [15:0] tag;
   } slot_type;

endpackage

// ===== rtl/core/grb_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module grb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/group_reorder_buffer.sv =====
// Group reorder buffer: stores finished groups by smallest id, releases them in id order
//
//   channel   dir   handshake            word
//   req       in    req_valid/req_ready  grb_pkg::req_word_type
//   rsp       out   rsp_valid/rsp_ready  grb_pkg::rsp_word_type
//
// One word is taken per pass of a sequencer around a single key comparator that walks
// the slot RAM one entry a cycle. At most 16 groups are released per word.
// Reset is synchronous and clears slot valid bits at once; no clearing pass is needed.
// A stalled rsp side holds the walk at the next release, once a word is already pending,
// or at the flush, until the output register frees.
module group_reorder_buffer #(
   parameter int DEPTH = grb_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  grb_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output grb_pkg::rsp_word_type rsp_data
);
   import grb_pkg::*;

`include "group_reorder_buffer_assert.svh"

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DUP   = 3'd1;
   localparam logic [2:0] S_DEC   = 3'd2;
   localparam logic [2:0] S_REL   = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [31:0]      next_exp_ff, next_exp_in;
   logic [31:0]      run_min_ff, run_min_in;
   logic [15:0]      run_cnt_ff, run_cnt_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [31:0]      grp_key_ff, grp_key_in;
   logic [15:0]      grp_size_ff, grp_size_in;
   logic [15:0]      grp_tag_ff, grp_tag_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             chk_ff, chk_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             dup_ff, dup_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic [RUN_W-1:0] n_ff, n_in;
   rsp_word_type     pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_word_type     rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             ram_we;
   slot_type         ram_wdata;
   logic             ram_re;
   logic [63:0]      ram_rdata;
   slot_type         rd_slot;
   logic [31:0]      cmp_key;
   logic             key_eq;
   logic             match;
   logic             out_free;
   logic             emit_ok;
   logic             scan_end;
   logic             idx_more;
   logic [31:0]      min_new;
   logic [15:0]      cnt_new;
   logic [RUN_W-1:0] n_next;

   grb_ram #(
      .WIDTH($bits(slot_type)),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_slot   = slot_type'(ram_rdata);
   assign cmp_key   = (state_ff == S_DUP) ? grp_key_ff : next_exp_ff;
   assign key_eq    = (rd_slot.key == cmp_key);
   assign match     = chk_ff && valid_ff[chk_idx_ff] && key_eq;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_ok   = !pend_valid_ff || out_free;
   assign idx_more  = (idx_ff != CNT_W'(DEPTH));
   assign scan_end  = !idx_more && !chk_ff;
   assign min_new   = (req_data.member_id < run_min_ff) ? req_data.member_id : run_min_ff;
   assign cnt_new   = (run_cnt_ff == COUNT_MAX) ? run_cnt_ff : run_cnt_ff + 16'd1;
   assign n_next    = n_ff + RUN_W'(1);
   assign ram_wdata = '{key: grp_key_ff, size: grp_size_ff, tag: grp_tag_ff};

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      next_exp_in   = next_exp_ff;
      run_min_in    = run_min_ff;
      run_cnt_in    = run_cnt_ff;
      valid_in      = valid_ff;
      grp_key_in    = grp_key_ff;
      grp_size_in   = grp_size_ff;
      grp_tag_in    = grp_tag_ff;
      idx_in        = idx_ff;
      chk_in        = chk_ff;
      chk_idx_in    = chk_idx_ff;
      dup_in        = dup_ff;
      found_in      = found_ff;
      free_in       = free_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n_in   = '0;
               idx_in = '0;
               chk_in = 1'b0;
               if (req_data.last_member) begin
                  grp_key_in  = min_new;
                  grp_size_in = cnt_new;
                  grp_tag_in  = req_data.group_tag;
                  run_min_in  = MIN_RESET;
                  run_cnt_in  = '0;
                  dup_in      = 1'b0;
                  found_in    = 1'b0;
                  state_in    = S_DUP;
               end else begin
                  run_min_in = min_new;
                  run_cnt_in = cnt_new;
                  state_in   = S_REL;
               end
            end
         end
         S_DUP: begin
            ram_re     = idx_more;
            chk_in     = idx_more;
            chk_idx_in = idx_ff[IDX_W-1:0];
            if (idx_more) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (chk_ff) begin
               if (valid_ff[chk_idx_ff]) begin
                  if (key_eq) begin
                     dup_in = 1'b1;
                  end
               end else if (!found_ff) begin
                  found_in = 1'b1;
                  free_in  = chk_idx_ff;
               end
            end
            if (scan_end) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (dup_ff || !found_ff) begin
               pend_in.out_tag      = grp_tag_ff;
               pend_in.out_first_id = grp_key_ff;
               pend_in.out_size     = grp_size_ff;
               pend_in.status       = dup_ff ? ST_DUP_KEY : ST_FULL;
               pend_in.last_of_run  = 1'b0;
               pend_valid_in        = 1'b1;
               n_in                 = n_next;
            end else begin
               ram_we            = 1'b1;
               valid_in[free_ff] = 1'b1;
            end
            idx_in   = '0;
            chk_in   = 1'b0;
            state_in = S_REL;
         end
         S_REL: begin
            if (match) begin
               if (emit_ok) begin
                  if (pend_valid_ff) begin
                     rsp_data_in  = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in.out_tag      = rd_slot.tag;
                  pend_in.out_first_id = rd_slot.key;
                  pend_in.out_size     = rd_slot.size;
                  pend_in.status       = ST_RELEASED;
                  pend_in.last_of_run  = 1'b0;
                  pend_valid_in        = 1'b1;
                  next_exp_in          = next_exp_ff + 32'(rd_slot.size);
                  valid_in[chk_idx_ff] = 1'b0;
                  n_in                 = n_next;
                  idx_in               = '0;
                  chk_in               = 1'b0;
                  state_in = (n_next == RUN_W'(RESULT_CAP)) ? S_FLUSH : S_REL;
               end
            end else begin
               ram_re     = idx_more;
               chk_in     = idx_more;
               chk_idx_in = idx_ff[IDX_W-1:0];
               if (idx_more) begin
                  idx_in = idx_ff + CNT_W'(1);
               end
               if (scan_end) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_data_in             = pend_ff;
               rsp_data_in.last_of_run = 1'b1;
               rsp_valid_in            = 1'b1;
               pend_valid_in           = 1'b0;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_exp_ff   <= NEXT_RESET;
         run_min_ff    <= MIN_RESET;
         run_cnt_ff    <= '0;
         valid_ff      <= '0;
         idx_ff        <= '0;
         chk_ff        <= 1'b0;
         dup_ff        <= 1'b0;
         found_ff      <= 1'b0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_exp_ff   <= next_exp_in;
         run_min_ff    <= run_min_in;
         run_cnt_ff    <= run_cnt_in;
         valid_ff      <= valid_in;
         idx_ff        <= idx_in;
         chk_ff        <= chk_in;
         dup_ff        <= dup_in;
         found_ff      <= found_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_key_ff  <= grp_key_in;
      grp_size_ff <= grp_size_in;
      grp_tag_ff  <= grp_tag_in;
      chk_idx_ff  <= chk_idx_in;
      free_ff     <= free_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   `GRB_ASSERT_NOW(a_idle_no_pending, state_ff == S_IDLE, !pend_valid_ff)
   `GRB_ASSERT_NOW(a_run_within_cap, 1'b1, n_ff <= RUN_W'(RESULT_CAP))
   `GRB_ASSERT_NEXT(a_release_frees_slot, (state_ff == S_REL) && match && emit_ok,
      !valid_ff[$past(chk_idx_ff)])
   `GRB_ASSERT_NEXT(a_flush_to_idle, (state_ff == S_FLUSH) && !pend_valid_ff,
      state_ff == S_IDLE)

endmodule
